/* hw/rtl/telephone_line_call_state_controller_defines.svh */
// Assertion macros for the telephone line call state controller.
// Included by the files that carry concurrent checks; depends on nothing.
`ifndef TELEPHONE_LINE_CALL_STATE_CONTROLLER_DEFINES_SVH
`define TELEPHONE_LINE_CALL_STATE_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset
`define TLCSC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlcsc check failed: same-cycle implication");
// Next-cycle implication, checked at every rising edge outside reset
`define TLCSC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlcsc check failed: next-cycle implication");
`else
`define TLCSC_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define TLCSC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* hw/rtl/tlcsc_pkg.sv */
// Shared types, codes and helpers of the telephone line call state controller.
// Used by the event step logic and the top level.
package tlcsc_pkg;

   localparam int unsigned MaxResults = 4;

   typedef enum logic [4:0] {
      OP_OPEN         = 5'd0,
      OP_INIT         = 5'd1,
      OP_UNINIT       = 5'd2,
      OP_OUT_OF_SVC   = 5'd3,
      OP_IN_SVC       = 5'd4,
      OP_BLOCKED      = 5'd5,
      OP_UNBLOCKED    = 5'd6,
      OP_SEIZURE      = 5'd7,
      OP_DIGIT        = 5'd8,
      OP_OFFERED      = 5'd9,
      OP_ACCEPT       = 5'd10,
      OP_ANSWERED     = 5'd11,
      OP_DIALING      = 5'd12,
      OP_PROCEEDING   = 5'd13,
      OP_ALERTING     = 5'd14,
      OP_CONNECTED    = 5'd15,
      OP_CALLSTATUS   = 5'd16,
      OP_DISCONNECTED = 5'd17,
      OP_DROPPED      = 5'd18,
      OP_RELEASED     = 5'd19,
      OP_FATAL        = 5'd20,
      OP_RESET_DONE   = 5'd21,
      OP_OUTBOUND_OK  = 5'd22,
      OP_REJECT_REQ   = 5'd23
   } op_type;

   typedef enum logic [2:0] {
      LS_CLOSED   = 3'd0,
      LS_UNINIT   = 3'd1,
      LS_IDLE     = 3'd2,
      LS_BLOCKING = 3'd3,
      LS_OOS      = 3'd4,
      LS_ACTIVE   = 3'd5
   } line_state_type;

   typedef enum logic [3:0] {
      CS_INVALID      = 4'd0,
      CS_SEIZURE      = 4'd1,
      CS_DIGITS       = 4'd2,
      CS_INCOMING     = 4'd3,
      CS_ACCEPTING    = 4'd4,
      CS_ANSWERING    = 4'd5,
      CS_REJECTING    = 4'd6,
      CS_CONNECTED    = 4'd7,
      CS_DISCONNECTED = 4'd8,
      CS_OUTBOUND     = 4'd9,
      CS_PLACING      = 4'd10,
      CS_PROCEEDING   = 4'd11,
      CS_ALERTING     = 4'd12
   } call_state_type;

   typedef enum logic [2:0] {
      ER_FAR      = 3'd0,
      ER_BUSY     = 3'd1,
      ER_NOANSWER = 3'd2,
      ER_NETBUSY  = 3'd3,
      ER_FAILED   = 3'd4,
      ER_NEAR     = 3'd5
   } exit_reason_type;

   typedef enum logic [2:0] {
      CMD_NONE     = 3'd0,
      CMD_WAIT     = 3'd1,
      CMD_DROP     = 3'd2,
      CMD_DROP_REJ = 3'd3,
      CMD_RELEASE  = 3'd4,
      CMD_RESET    = 3'd5
   } command_type;

   typedef enum logic [4:0] {
      RPT_NONE         = 5'd0,
      RPT_CLOSED       = 5'd1,
      RPT_OPENED       = 5'd2,
      RPT_INITIALIZED  = 5'd3,
      RPT_UNINIT       = 5'd4,
      RPT_BLOCK        = 5'd5,
      RPT_UNBLOCK      = 5'd6,
      RPT_OUT_OF_SVC   = 5'd7,
      RPT_IN_SVC       = 5'd8,
      RPT_SEIZURE      = 5'd9,
      RPT_DIGIT        = 5'd10,
      RPT_INCOMING     = 5'd11,
      RPT_ACCEPTING    = 5'd12,
      RPT_REJECTING    = 5'd13,
      RPT_ANSWERING    = 5'd14,
      RPT_OUTBOUND     = 5'd15,
      RPT_PLACING      = 5'd16,
      RPT_PROCEEDING   = 5'd17,
      RPT_ALERTING     = 5'd18,
      RPT_CONNECTED    = 5'd19,
      RPT_DISCONNECTED = 5'd20,
      RPT_RELEASED     = 5'd21
   } report_type;

   // Failure classes of call_result; no-answer and timeout share one exit reason
   localparam logic [2:0] ClsBusy     = 3'd0;
   localparam logic [2:0] ClsNoAnswer = 3'd1;
   localparam logic [2:0] ClsTimeout  = 3'd2;
   localparam logic [2:0] ClsReject   = 3'd3;

   typedef struct packed {
      line_state_type  line_state;
      call_state_type  call_state;
      logic            direction;
      exit_reason_type exit_reason;
      logic            established;
      logic            near_dropped;
   } state_type;

   typedef struct packed {
      report_type      report_code;
      command_type     command;
      line_state_type  line_state_out;
      call_state_type  call_state_out;
      logic            direction_out;
      exit_reason_type exit_reason_out;
      logic            last;
   } result_type;

   localparam state_type StateReset = '{
      line_state:   LS_CLOSED,
      call_state:   CS_INVALID,
      direction:    1'b0,
      exit_reason:  ER_FAR,
      established:  1'b0,
      near_dropped: 1'b1
   };

   // Build one result with a snapshot of the current states
   function automatic result_type mk_result(input report_type rep, input command_type cmd,
                                            input state_type st);
      result_type r;
      r.report_code     = rep;
      r.command         = cmd;
      r.line_state_out  = st.line_state;
      r.call_state_out  = st.call_state;
      r.direction_out   = st.direction;
      r.exit_reason_out = st.exit_reason;
      r.last            = 1'b0;
      return r;
   endfunction

   // Move the call state; invalid forces the line idle, seizure and outbound force it active
   function automatic state_type set_call(input state_type st, input call_state_type cs);
      state_type s;
      s            = st;
      s.call_state = cs;
      if (cs == CS_INVALID) begin
         s.line_state = LS_IDLE;
      end else if (cs == CS_SEIZURE || cs == CS_OUTBOUND) begin
         s.line_state = LS_ACTIVE;
      end
      return s;
   endfunction

endpackage

/* hw/rtl/tlcsc_req_if.sv */
// Event channel of the telephone line call state controller.
// Carries valid, ready and one event; depends on nothing.
interface tlcsc_req_if;
   logic       valid;
   logic       ready;
   logic [4:0] operation;
   logic [2:0] call_result;

   modport source (output valid, output operation, output call_result, input ready);
   modport sink   (input valid, input operation, input call_result, output ready);
endinterface

/* hw/rtl/tlcsc_rsp_if.sv */
// Result channel of the telephone line call state controller.
// Carries valid, ready and one report or command result; depends on nothing.
interface tlcsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] report_code;
   logic [2:0] command;
   logic [2:0] line_state_out;
   logic [3:0] call_state_out;
   logic       direction_out;
   logic [2:0] exit_reason_out;
   logic       last;

   modport source (output valid, output report_code, output command, output line_state_out,
                   output call_state_out, output direction_out, output exit_reason_out,
                   output last, input ready);
   modport sink   (input valid, input report_code, input command, input line_state_out,
                   input call_state_out, input direction_out, input exit_reason_out,
                   input last, output ready);
endinterface

/* hw/rtl/telephone_line_call_state_controller.sv */
// Telephone line and call state controller.
// Event channel in (req_ch), result channel out (rsp_ch), one event at a time.
// An accepted event updates the line state, call state, direction, exit reason
// and the established and near-dropped flags at the accepting edge; the zero
// to four results it causes are latched together into a result queue.
// Results leave rsp_ch in order, one per cycle while rsp_ch.ready is high,
// starting the cycle after the event is accepted; the final one carries last.
// An event with no result (unknown code or refused guard) leaves nothing on
// rsp_ch. The next event is taken in the cycle the last result of the previous
// one is taken, so an event's results occupy the four-entry result queue until
// then; an event with no result leaves the queue empty.
// When the receiver stalls, the queue holds and req_ch.ready stays low until
// the final result is taken. Reset (synchronous) returns the line to closed,
// the call to invalid, inbound, far end, not established and near-dropped,
// and empties the result queue.
// Depends on tlcsc_pkg, tlcsc_req_if, tlcsc_rsp_if, tlcsc_step and the
// assertion macro header.
`include "telephone_line_call_state_controller_defines.svh"

module telephone_line_call_state_controller (
   input logic         clock,
   input logic         reset,
   tlcsc_req_if.sink   req_ch,
   tlcsc_rsp_if.source rsp_ch
);
   import tlcsc_pkg::*;

   state_type        state_ff;
   state_type        state_in;
   state_type        step_state;
   result_type [3:0] step_res;
   logic [2:0]       step_cnt;

   result_type [3:0] res_ff;
   result_type [3:0] res_in;
   logic [2:0]       cnt_ff;
   logic [2:0]       cnt_in;

   logic             req_acc;
   logic             rsp_take;

   // Compute the next state and the results of the offered event
   tlcsc_step u_step (
      .cur_state   (state_ff),
      .operation   (req_ch.operation),
      .call_result (req_ch.call_result),
      .nxt_state   (step_state),
      .results     (step_res),
      .count       (step_cnt)
   );

   // Take a new event once the queue is empty or its final entry leaves now
   assign rsp_take     = rsp_ch.valid & rsp_ch.ready;
   assign req_ch.ready = (cnt_ff == 3'd0) | ((cnt_ff == 3'd1) & rsp_ch.ready);
   assign req_acc      = req_ch.valid & req_ch.ready;

   // Load the queue on accept, otherwise shift out the taken entry
   always_comb begin
      state_in = state_ff;
      res_in   = res_ff;
      cnt_in   = cnt_ff;
      if (req_acc) begin
         state_in = step_state;
         res_in   = step_res;
         cnt_in   = step_cnt;
      end else if (rsp_take) begin
         res_in = {res_ff[3], res_ff[3:1]};
         cnt_in = cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StateReset;
         cnt_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Payload registers hold without reset
   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   // Drive the head of the queue
   assign rsp_ch.valid           = (cnt_ff != 3'd0);
   assign rsp_ch.report_code     = res_ff[0].report_code;
   assign rsp_ch.command         = res_ff[0].command;
   assign rsp_ch.line_state_out  = res_ff[0].line_state_out;
   assign rsp_ch.call_state_out  = res_ff[0].call_state_out;
   assign rsp_ch.direction_out   = res_ff[0].direction_out;
   assign rsp_ch.exit_reason_out = res_ff[0].exit_reason_out;
   assign rsp_ch.last            = res_ff[0].last;

   // Checks
   `TLCSC_ASSERT_NOW(a_last_on_final, clock, reset, rsp_ch.valid, rsp_ch.last == (cnt_ff == 3'd1))
   `TLCSC_ASSERT_NEXT(a_results_follow, clock, reset, req_acc && (step_cnt != 3'd0), rsp_ch.valid && (cnt_ff == $past(step_cnt)))
   `TLCSC_ASSERT_NOW(a_active_has_call, clock, reset, state_ff.line_state == LS_ACTIVE, state_ff.call_state != CS_INVALID)
   `TLCSC_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, cnt_ff <= 3'd4)

endmodule

/* hw/rtl/tlcsc_step.sv */
// Event step logic: applies one event to the line and call state and lists
// the up to four results it causes. Depends on tlcsc_pkg.
module tlcsc_step (
   input  tlcsc_pkg::state_type       cur_state,
   input  logic [4:0]                 operation,
   input  logic [2:0]                 call_result,
   output tlcsc_pkg::state_type       nxt_state,
   output tlcsc_pkg::result_type [3:0] results,
   output logic [2:0]                 count
);
   import tlcsc_pkg::*;

   state_type        st;
   result_type [3:0] res;
   logic [2:0]       n;

   always_comb begin
      st  = cur_state;
      res = '0;
      n   = 3'd0;
      unique case (op_type'(operation))
         OP_OPEN: begin
            if (st.line_state == LS_CLOSED) st.line_state = LS_UNINIT;
            res[n[1:0]] = mk_result(RPT_OPENED, CMD_NONE, st); n = n + 3'd1;
         end
         OP_INIT: begin
            if (st.line_state == LS_UNINIT) st.line_state = LS_IDLE;
            res[n[1:0]] = mk_result(RPT_INITIALIZED, CMD_NONE, st); n = n + 3'd1;
         end
         OP_UNINIT: begin
            st.line_state = LS_UNINIT;
            res[n[1:0]] = mk_result(RPT_UNINIT, CMD_NONE, st); n = n + 3'd1;
         end
         OP_OUT_OF_SVC: begin
            st.line_state = LS_OOS;
            res[n[1:0]] = mk_result(RPT_OUT_OF_SVC, CMD_NONE, st); n = n + 3'd1;
         end
         OP_IN_SVC: begin
            if (st.line_state == LS_OOS) st.line_state = LS_IDLE;
            res[n[1:0]] = mk_result(RPT_IN_SVC, CMD_NONE, st); n = n + 3'd1;
         end
         OP_BLOCKED: begin
            st.line_state = LS_BLOCKING;
            res[n[1:0]] = mk_result(RPT_BLOCK, CMD_NONE, st); n = n + 3'd1;
         end
         OP_UNBLOCKED: begin
            res[n[1:0]] = mk_result(RPT_NONE, CMD_WAIT, st); n = n + 3'd1;
            if (st.line_state == LS_BLOCKING) st.line_state = LS_IDLE;
            res[n[1:0]] = mk_result(RPT_UNBLOCK, CMD_NONE, st); n = n + 3'd1;
         end
         OP_SEIZURE: begin
            if (st.line_state == LS_IDLE) begin
               st           = set_call(st, CS_SEIZURE);
               st.direction = 1'b0;
               res[n[1:0]] = mk_result(RPT_SEIZURE, CMD_NONE, st); n = n + 3'd1;
            end
         end
         OP_DIGIT: begin
            if (st.call_state == CS_SEIZURE) st = set_call(st, CS_DIGITS);
            res[n[1:0]] = mk_result(RPT_DIGIT, CMD_NONE, st); n = n + 3'd1;
         end
         OP_OFFERED: begin
            if (st.call_state == CS_SEIZURE || st.call_state == CS_DIGITS) begin
               st = set_call(st, CS_INCOMING);
            end
            res[n[1:0]] = mk_result(RPT_INCOMING, CMD_NONE, st); n = n + 3'd1;
         end
         OP_ACCEPT: begin
            if (st.call_state == CS_INCOMING) begin
               st = set_call(st, CS_ACCEPTING);
               res[n[1:0]] = mk_result(RPT_ACCEPTING, CMD_NONE, st); n = n + 3'd1;
            end
         end
         OP_ANSWERED: begin
            st.established = 1'b1;
            if (st.call_state == CS_INCOMING || st.call_state == CS_ACCEPTING) begin
               st = set_call(st, CS_ANSWERING);
            end
            res[n[1:0]] = mk_result(RPT_ANSWERING, CMD_NONE, st); n = n + 3'd1;
            // answering always qualifies for the connected step
            if (st.call_state == CS_ANSWERING || st.call_state == CS_ACCEPTING ||
                st.call_state == CS_OUTBOUND  || st.call_state == CS_PLACING   ||
                st.call_state == CS_PROCEEDING || st.call_state == CS_ALERTING) begin
               st = set_call(st, CS_CONNECTED);
               res[n[1:0]] = mk_result(RPT_CONNECTED, CMD_NONE, st); n = n + 3'd1;
            end
         end
         OP_DIALING: begin
            if (st.call_state == CS_OUTBOUND) st = set_call(st, CS_PLACING);
            res[n[1:0]] = mk_result(RPT_PLACING, CMD_NONE, st); n = n + 3'd1;
         end
         OP_PROCEEDING: begin
            if (st.call_state == CS_OUTBOUND || st.call_state == CS_PLACING) begin
               st = set_call(st, CS_PROCEEDING);
            end
            res[n[1:0]] = mk_result(RPT_PROCEEDING, CMD_NONE, st); n = n + 3'd1;
         end
         OP_ALERTING: begin
            if (st.call_state == CS_OUTBOUND || st.call_state == CS_PLACING ||
                st.call_state == CS_PROCEEDING) begin
               st = set_call(st, CS_ALERTING);
            end
            res[n[1:0]] = mk_result(RPT_ALERTING, CMD_NONE, st); n = n + 3'd1;
         end
         OP_CONNECTED: begin
            if (st.call_state == CS_ANSWERING || st.call_state == CS_ACCEPTING ||
                st.call_state == CS_OUTBOUND  || st.call_state == CS_PLACING   ||
                st.call_state == CS_PROCEEDING || st.call_state == CS_ALERTING) begin
               st = set_call(st, CS_CONNECTED);
               res[n[1:0]] = mk_result(RPT_CONNECTED, CMD_NONE, st); n = n + 3'd1;
            end
            st.established = 1'b1;
         end
         OP_CALLSTATUS, OP_DISCONNECTED: begin
            // classify the failure unless the call was already up
            if (st.established) begin
               st.exit_reason = ER_FAR;
            end else if (call_result == ClsBusy) begin
               st.exit_reason = ER_BUSY;
            end else if (call_result == ClsNoAnswer || call_result == ClsTimeout) begin
               st.exit_reason = ER_NOANSWER;
            end else if (call_result == ClsReject) begin
               st.exit_reason = ER_NETBUSY;
            end else begin
               st.exit_reason = ER_FAILED;
            end
            st.near_dropped = 1'b0;
            res[n[1:0]] = mk_result(RPT_NONE, CMD_DROP, st); n = n + 3'd1;
         end
         OP_DROPPED: begin
            if (st.near_dropped) st.exit_reason = ER_NEAR;
            if (st.call_state != CS_INVALID) begin
               st = set_call(st, CS_DISCONNECTED);
               res[n[1:0]] = mk_result(RPT_DISCONNECTED, CMD_NONE, st); n = n + 3'd1;
               res[n[1:0]] = mk_result(RPT_NONE, CMD_RELEASE, st); n = n + 3'd1;
            end
         end
         OP_RELEASED: begin
            st = set_call(st, CS_INVALID);
            res[n[1:0]] = mk_result(RPT_RELEASED, CMD_NONE, st); n = n + 3'd1;
            st.established  = 1'b0;
            st.near_dropped = 1'b1;
         end
         OP_FATAL: begin
            res[n[1:0]] = mk_result(RPT_NONE, CMD_RESET, st); n = n + 3'd1;
         end
         OP_RESET_DONE: begin
            // close, reopen, wait and unblock; the line ends uninitialized
            st.line_state = LS_CLOSED;
            res[n[1:0]] = mk_result(RPT_CLOSED, CMD_NONE, st); n = n + 3'd1;
            st.line_state = LS_UNINIT;
            res[n[1:0]] = mk_result(RPT_OPENED, CMD_NONE, st); n = n + 3'd1;
            res[n[1:0]] = mk_result(RPT_NONE, CMD_WAIT, st); n = n + 3'd1;
            res[n[1:0]] = mk_result(RPT_UNBLOCK, CMD_NONE, st); n = n + 3'd1;
         end
         OP_OUTBOUND_OK: begin
            if (st.call_state == CS_INVALID) begin
               st           = set_call(st, CS_OUTBOUND);
               st.direction = 1'b1;
               res[n[1:0]] = mk_result(RPT_OUTBOUND, CMD_NONE, st); n = n + 3'd1;
            end
         end
         OP_REJECT_REQ: begin
            if (st.call_state == CS_INCOMING || st.call_state == CS_ACCEPTING) begin
               st = set_call(st, CS_REJECTING);
            end
            res[n[1:0]] = mk_result(RPT_REJECTING, CMD_NONE, st); n = n + 3'd1;
            res[n[1:0]] = mk_result(RPT_NONE, CMD_DROP_REJ, st); n = n + 3'd1;
         end
         default: begin
            // unknown event: no change, no result
         end
      endcase

      // flag the final result of this event
      if (n != 3'd0) res[n[1:0] - 2'd1].last = 1'b1;
   end

   assign nxt_state = st;
   assign results   = res;
   assign count     = n;

endmodule
